// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

   localparam int BYTE_W = 8;
   localparam int CFG_DATA_W = 64;
   localparam int LEN_W = 4;
   localparam int MAX_BYTES = CFG_DATA_W / BYTE_W;
   localparam int IDX_W = $clog2(MAX_BYTES);

   localparam int DEFAULT_MAX_PATTERN = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int RLEN_CAP = (MAX_REPLACEMENT < MAX_BYTES) ? MAX_REPLACEMENT : MAX_BYTES;

   // power of two, so the pointers wrap on their own
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_DATA_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]      pattern_length;
      logic [CFG_DATA_W-1:0] replacement_bytes;
      logic [LEN_W-1:0]      replacement_length;
   } cfg_type;

   // at most one command per input item: bytes to send, oldest in the lowest byte
   typedef struct packed {
      logic [CFG_DATA_W-1:0] data;
      logic [LEN_W-1:0]      count;
      logic                  last;
   } cmd_type;

endpackage

// ===== sv/sfr_front.sv =====
module sfr_front #(
   parameter int MAX_PATTERN = sfr_pkg::DEFAULT_MAX_PATTERN
) (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::cfg_type cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // in_byte
   input  logic             req_tlast,   // in_last
   input  logic             q_full,
   output logic             q_push,
   output sfr_pkg::cmd_type q_cmd
);
   import sfr_pkg::*;

   localparam int WIN_DEPTH = (MAX_PATTERN < MAX_BYTES) ? MAX_PATTERN : MAX_BYTES;
   localparam int WIN_W = WIN_DEPTH * BYTE_W;

   logic [WIN_W-1:0] win_ff, win_in;
   logic [LEN_W-1:0] fill_ff, fill_in;

   logic [LEN_W-1:0] plen, rlen, base, shift, fill_new;
   logic [WIN_W-1:0] shifted, w;
   logic             match, fire, need_cmd;
   cmd_type          cmd;

   assign req_tready = !q_full;
   assign fire = req_tvalid && req_tready;
   assign q_push = fire && need_cmd;
   assign q_cmd = cmd;

   always_comb begin
      plen = cfg.pattern_length;
      if (plen == '0) plen = LEN_W'(1);
      if (plen > LEN_W'(WIN_DEPTH)) plen = LEN_W'(WIN_DEPTH);
      rlen = cfg.replacement_length;
      if (rlen > LEN_W'(RLEN_CAP)) rlen = LEN_W'(RLEN_CAP);
   end

   // drop the oldest excess bytes so one slot is free, take the byte in, then compare with the pattern
   always_comb begin
      if (fill_ff >= plen) begin
         base = plen - LEN_W'(1);
         shift = fill_ff - base;
      end else begin
         base = fill_ff;
         shift = '0;
      end
      shifted = win_ff >> {shift, 3'b000};
      for (int k = 0; k < WIN_DEPTH; k++) begin
         w[k*BYTE_W +: BYTE_W] = (LEN_W'(k) == base) ? req_tdata : shifted[k*BYTE_W +: BYTE_W];
      end
      fill_new = base + LEN_W'(1);
      match = 1'b1;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (LEN_W'(k) < plen
             && w[k*BYTE_W +: BYTE_W] != cfg.pattern_bytes[k*BYTE_W +: BYTE_W]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      win_in = w;
      fill_in = fill_new;
      need_cmd = 1'b0;
      cmd.data = CFG_DATA_W'(w);
      cmd.count = '0;
      cmd.last = req_tlast;
      if (fill_new == plen) begin
         if (match) begin
            cmd.data = cfg.replacement_bytes;
            cmd.count = rlen;
            fill_in = '0;
            need_cmd = (rlen != '0) || req_tlast;
         end else begin
            // send the oldest byte, or the whole window at the end
            cmd.count = req_tlast ? plen : LEN_W'(1);
            need_cmd = 1'b1;
            win_in = w >> BYTE_W;
            fill_in = plen - LEN_W'(1);
         end
      end else if (req_tlast) begin
         cmd.count = fill_new;
         need_cmd = 1'b1;
      end
      if (req_tlast) fill_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (fire) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== sv/sfr_queue.sv =====
module sfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output sfr_pkg::cmd_type head_cmd
);
   import sfr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/sfr_back.sv =====
module sfr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  sfr_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tuser,   // out_empty
   output logic             rsp_tlast    // out_last
);
   import sfr_pkg::*;

   cmd_type          cur_ff;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] final_idx;
   logic             at_final, fire, done;
   logic [CFG_DATA_W-1:0] sel;

   // an empty command still gives one marker result
   assign final_idx = (cur_ff.count == '0) ? '0 : IDX_W'(cur_ff.count - LEN_W'(1));
   assign at_final = idx_ff == final_idx;
   assign fire = rsp_tvalid && rsp_tready;
   assign done = fire && at_final;
   assign pop = head_valid && (!busy_ff || done);

   assign sel = cur_ff.data >> {idx_ff, 3'b000};
   assign rsp_tvalid = busy_ff;
   assign rsp_tuser = cur_ff.count == '0;
   assign rsp_tdata = rsp_tuser ? '0 : sel[BYTE_W-1:0];
   assign rsp_tlast = cur_ff.last && at_final;

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_cmd;
      end
   end

endmodule

// ===== sv/stream_find_replace_unit.sv =====
// Streaming find-and-replace on a byte stream. Each accepted byte on req_ enters a window as
// long as the pattern; a full window that matches is replaced by the replacement bytes (none
// when replacement_length is zero), otherwise its oldest byte goes out on rsp_. req_tlast
// flushes the window and the final result carries rsp_tlast; if nothing is left to send, one
// result with rsp_tuser (empty) set ends the run. The front takes one byte per cycle while the
// two-entry command queue has room; the back sends one result per cycle while rsp_tready is
// high, through the single output byte lane, and an item gives up to eight results for a
// replacement or an end-of-run flush. Write the csr_ registers only while idle.
module stream_find_replace_unit #(
   parameter int MAX_PATTERN = sfr_pkg::DEFAULT_MAX_PATTERN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tuser,   // out_empty
   output logic        rsp_tlast    // out_last
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cmd_type push_cmd, head_cmd;
   logic    q_push, q_full, q_pop, q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes <= '0;
         cfg_ff.pattern_length <= LEN_W'(1);
         cfg_ff.replacement_bytes <= '0;
         cfg_ff.replacement_length <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:      cfg_ff.pattern_bytes <= csr_wdata;
            CSR_PATTERN_LENGTH:     cfg_ff.pattern_length <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  cfg_ff.replacement_bytes <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: cfg_ff.replacement_length <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   sfr_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command taken from an empty queue");

   a_empty_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("empty marker result without end of run");

endmodule

// ===== test/stream_find_replace_checker.sv =====
module stream_find_replace_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       empty;
      logic       last;
   } out_item_type;

   localparam int PLEN_CAP = (DEFAULT_MAX_PATTERN < MAX_BYTES) ? DEFAULT_MAX_PATTERN : MAX_BYTES;

   logic [63:0]  pat_word;
   logic [3:0]   pat_len;
   logic [63:0]  rep_word;
   logic [3:0]   rep_len;
   logic [7:0]   win [MAX_BYTES];
   int           win_fill;
   out_item_type rewritten_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // work out the rewritten bytes that one source byte releases
   task automatic rewrite_byte(input logic [7:0] b, input logic fin);
      out_item_type batch [2*MAX_BYTES];
      int           n;
      int           plen;
      int           rlen;
      int           drop;
      bit           hit;
      n    = 0;
      plen = (pat_len == 0) ? 1 : ((pat_len > PLEN_CAP) ? PLEN_CAP : pat_len);
      rlen = (rep_len > RLEN_CAP) ? RLEN_CAP : rep_len;

      // pattern shortened while bytes wait: drop the oldest excess unsent
      if (win_fill >= plen) begin
         drop = win_fill - (plen - 1);
         for (int k = 0; k < plen - 1; k++) win[k] = win[k + drop];
         win_fill = plen - 1;
      end
      win[win_fill] = b;
      win_fill++;

      if (win_fill == plen) begin
         hit = 1'b1;
         for (int k = 0; k < plen; k++)
            if (win[k] != pat_word[8*k +: 8]) hit = 1'b0;
         if (hit) begin
            for (int k = 0; k < rlen; k++) begin
               batch[n] = '{rep_word[8*k +: 8], 1'b0, 1'b0};
               n++;
            end
            win_fill = 0;
         end else begin
            batch[n] = '{win[0], 1'b0, 1'b0};
            n++;
            for (int k = 0; k < plen - 1; k++) win[k] = win[k + 1];
            win_fill--;
         end
      end

      if (fin) begin
         for (int k = 0; k < win_fill; k++) begin
            batch[n] = '{win[k], 1'b0, 1'b0};
            n++;
         end
         win_fill = 0;
         // nothing left to send: end the run with an empty marker
         if (n == 0) begin
            batch[n] = '{8'h00, 1'b1, 1'b0};
            n++;
         end
         batch[n-1].last = 1'b1;
      end

      for (int k = 0; k < n; k++) rewritten_q.insert(rewritten_q.size(), batch[k]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pat_word = '0;
         pat_len  = 4'd1;
         rep_word = '0;
         rep_len  = 4'd0;
         win_fill = 0;
         rewritten_q.delete();
      end else begin
         // check the outgoing item before predicting from the incoming one
         if (rsp_tvalid && rsp_tready) begin
            if (rewritten_q.size() == 0) begin
               report($sformatf("unexpected item data %02h empty %b last %b",
                                rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               out_item_type want;
               want = rewritten_q.pop_front();
               if (rsp_tdata !== want.data)
                  report($sformatf("out_byte want %02h got %02h", want.data, rsp_tdata));
               if (rsp_tuser !== want.empty)
                  report($sformatf("out_empty want %b got %b", want.empty, rsp_tuser));
               if (rsp_tlast !== want.last)
                  report($sformatf("out_last want %b got %b", want.last, rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) rewrite_byte(req_tdata, req_tlast);
         // a register write takes effect from the next item on
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_BYTES:      pat_word = csr_wdata;
               CSR_PATTERN_LENGTH:     pat_len  = csr_wdata[3:0];
               CSR_REPLACEMENT_BYTES:  rep_word = csr_wdata;
               CSR_REPLACEMENT_LENGTH: rep_len  = csr_wdata[3:0];
               default: ;
            endcase
         end
      end
      pending = rewritten_q.size();
   end

endmodule

// ===== test/stream_find_replace_unit_tb.sv =====
module stream_find_replace_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;

   int          send_idle;
   int          recv_stall;
   logic [63:0] cur_pat;
   int          cur_plen;
   logic [7:0]  alpha [4];

   int          idle_pct  [4] = '{0, 82, 0, 22};
   int          stall_pct [4] = '{0, 0, 82, 22};

   stream_find_replace_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   stream_find_replace_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic set_rule(input logic [63:0] pat, input logic [63:0] plen,
                           input logic [63:0] rep, input logic [63:0] rlen);
      write_reg(CSR_PATTERN_BYTES, pat);
      write_reg(CSR_PATTERN_LENGTH, plen);
      write_reg(CSR_REPLACEMENT_BYTES, rep);
      write_reg(CSR_REPLACEMENT_LENGTH, rlen);
      cur_pat  = pat;
      cur_plen = (plen[3:0] == 0) ? 1 : ((plen[3:0] > 8) ? 8 : plen[3:0]);
   endtask

   // enter and leave at a falling edge; hold the item until taken
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = fin;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // drop valid, wait for every expected item, then let the pipeline empty
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_rule();
      logic [63:0] pat;
      logic [63:0] plen_w;
      logic [63:0] rlen_w;
      for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(255));
      for (int k = 0; k < 8; k++) pat[8*k +: 8] = alpha[$urandom_range(3)];
      plen_w = {$urandom(), $urandom()};
      rlen_w = {$urandom(), $urandom()};
      plen_w[3:0] = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(1, 8));
      rlen_w[3:0] = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8));
      set_rule(pat, plen_w, {$urandom(), $urandom()}, rlen_w);
   endtask

   // mostly whole or partial pattern copies, some alphabet and raw bytes
   task automatic run_stream(input int n);
      int sent;
      int r;
      int cut;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(9);
         if (r < 5) cut = cur_plen;
         else if (r < 7) cut = $urandom_range(1, cur_plen);
         else cut = 0;
         if (cut > 0) begin
            for (int k = 0; k < cut; k++) begin
               send_byte(cur_pat[8*k +: 8], $urandom_range(11) == 0);
               sent++;
            end
         end else begin
            if (r < 9) send_byte(alpha[$urandom_range(3)], $urandom_range(11) == 0);
            else send_byte(8'($urandom_range(255)), $urandom_range(11) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_PATTERN_BYTES;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      send_idle  = 0;
      recv_stall = 0;
      cur_pat    = '0;
      cur_plen   = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset rule: delete a single 00 byte
      send_byte(8'hFF, 1'b1);
      settle();
      set_rule(64'h0, 64'd0, 64'h0, 64'd0);
      send_byte(8'h00, 1'b1);
      settle();

      // widest pattern and replacement
      set_rule(64'hFFFF_FFFF_FFFF_FFFF, 64'd8, 64'h0123_4567_89AB_CDEF, 64'd8);
      for (int k = 0; k < 8; k++) send_byte(8'hFF, k == 7);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      settle();

      // lengths over range, then leave bytes waiting mid-stream
      set_rule(64'hFFFF_FFFF_FFFF_FFFF, 64'd15, 64'hFEDC_BA98_7654_3210, 64'd15);
      for (int k = 0; k < 8; k++) send_byte(8'hFF, 1'b0);
      settle();
      write_reg(CSR_REPLACEMENT_LENGTH, 64'd2);
      for (int k = 0; k < 3; k++) send_byte(8'hFF, 1'b0);
      settle();

      // shorten the pattern while three bytes wait
      set_rule(64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 64'h0000_0000_0000_005A, 64'd1);
      send_byte(8'hFF, 1'b1);
      settle();

      for (int p = 0; p < 4; p++) begin
         send_idle  = idle_pct[p];
         recv_stall = stall_pct[p];
         for (int s = 0; s < 3; s++) begin
            random_rule();
            run_stream(14);
            settle();
         end
      end

      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
